// ===== hdl/apn_pkg.sv =====
// apn_pkg: shared constants, types and helpers of the absolute path normaliser
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package apn_pkg;

    localparam int APN_OUT_BYTES     = 64;
    localparam int APN_SEGMENT_BYTES = 32;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;

    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       last;
    } apn_load_t;

    function automatic int apn_aw(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

// ===== hdl/apn_ram.sv =====
// apn_ram: generic simple dual-port ram, one write port and one registered read port
// depends on apn_pkg for the address width helper
`timescale 1ns / 1ps

module apn_ram
    import apn_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [apn_aw(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [apn_aw(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/apn_out_reg.sv =====
// apn_out_reg: output register of the result channel, holds one transaction under stall
// depends on apn_pkg for the load struct
`timescale 1ns / 1ps

module apn_out_reg
    import apn_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  apn_load_t ld,
    output logic      m_valid,
    input  logic      m_ready,
    output logic [7:0] m_out_byte,
    output logic      m_out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ld.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (ld.load) begin
            byte_reg <= ld.data;
            last_reg <= ld.last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;

endmodule

// ===== hdl/absolute_path_normalizer_unit.sv =====
// absolute_path_normalizer_unit: top level, sequencer around a component ram and a path ram
// depends on apn_pkg, apn_ram and apn_out_reg
//
// usage: path bytes enter on s_in_byte/s_in_last (valid/ready); '/' and '\' separate
// components, '.' is dropped, '..' removes the last component, others are appended.
// a zero byte ends the string; later bytes are ignored up to the one marked last.
// on the byte marked last the normalised path leaves on m_out_byte/m_out_last,
// one transaction per byte, m_out_last on the final one, at least a lone '/'.
// an ordinary byte is only stored; a separator or the last byte then closes the
// component: a slash is written, then each component byte is read and appended
// (component ram to path ram), or on '..' the path ram is read back byte by byte
// (its read port is registered) until a slash or the root is reached.
// on emission each output byte is read from the path ram and then loaded into
// the output register; a stall simply holds the output register and the
// sequencer. s_ready is low while a component is copied or popped and while the path
// is emitted, and rises again as the final byte is loaded, so the next path may start
// while that byte still waits to be taken.
// reset (aresetn low, synchronous) gives the empty path "/"; no clearing pass is needed.
`timescale 1ns / 1ps

module absolute_path_normalizer_unit
    import apn_pkg::*;
#(
    parameter int OUT_BYTES     = APN_OUT_BYTES,
    parameter int SEGMENT_BYTES = APN_SEGMENT_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    localparam int SAW = apn_aw(SEGMENT_BYTES - 1);
    localparam int SLW = $clog2(SEGMENT_BYTES);
    localparam int RAW = apn_aw(OUT_BYTES);
    localparam logic [SLW-1:0] SEG_MAX = SLW'(SEGMENT_BYTES - 1);
    localparam logic [RAW:0]   OUT_LIM = (RAW + 1)'(OUT_BYTES);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FIN     = 4'd1;
    localparam logic [3:0] ST_PUSH_SL = 4'd2;
    localparam logic [3:0] ST_PUSH_RD = 4'd3;
    localparam logic [3:0] ST_PUSH_WR = 4'd4;
    localparam logic [3:0] ST_POP_RD  = 4'd5;
    localparam logic [3:0] ST_POP_CK  = 4'd6;
    localparam logic [3:0] ST_EM_RD   = 4'd7;
    localparam logic [3:0] ST_EM_LD   = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [SLW-1:0] seg_len_reg, seg_len_next;
    logic [SLW-1:0] push_len_reg, push_len_next;
    logic [SLW-1:0] idx_reg, idx_next;
    logic           dot0_reg, dot0_next;
    logic           dot1_reg, dot1_next;
    logic [RAW-1:0] res_len_reg, res_len_next;
    logic           ends_slash_reg, ends_slash_next;
    logic           ended_reg, ended_next;
    logic           last_pend_reg, last_pend_next;
    logic [RAW-1:0] emit_idx_reg, emit_idx_next;

    logic           accept;
    logic           is_sep;
    logic           is_nul;
    logic           seg_we;
    logic           room_out;
    logic [3:0]     done_state;
    logic           emit_last;

    logic           res_we;
    logic [RAW-1:0] res_waddr;
    logic [7:0]     res_wdata;
    logic [RAW-1:0] res_raddr;
    logic [7:0]     res_rdata;
    logic [7:0]     seg_rdata;
    apn_load_t      out_ld;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign is_sep     = (s_in_byte == CHAR_SLASH) || (s_in_byte == CHAR_BSLASH);
    assign is_nul     = (s_in_byte == CHAR_NUL);
    assign seg_we     = accept && !ended_reg && !is_nul && !is_sep && (seg_len_reg < SEG_MAX);
    assign room_out   = (({1'b0, res_len_reg} + (RAW + 1)'(1)) < OUT_LIM);
    assign done_state = last_pend_reg ? ST_EM_RD : ST_IDLE;
    assign emit_last  = (({1'b0, emit_idx_reg} + (RAW + 1)'(1)) == {1'b0, res_len_reg});

    always_comb begin
        state_next      = state_reg;
        seg_len_next    = seg_len_reg;
        push_len_next   = push_len_reg;
        idx_next        = idx_reg;
        dot0_next       = dot0_reg;
        dot1_next       = dot1_reg;
        res_len_next    = res_len_reg;
        ends_slash_next = ends_slash_reg;
        ended_next      = ended_reg;
        last_pend_next  = last_pend_reg;
        emit_idx_next   = emit_idx_reg;
        res_we          = 1'b0;
        res_waddr       = res_len_reg;
        res_wdata       = CHAR_SLASH;
        res_raddr       = res_len_reg - RAW'(1);
        out_ld.load     = 1'b0;
        out_ld.data     = (emit_idx_reg == '0) ? CHAR_SLASH : res_rdata;
        out_ld.last     = emit_last;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_pend_next = s_in_last;
                    if (!ended_reg) begin
                        if (seg_we) begin
                            seg_len_next = seg_len_reg + SLW'(1);
                            if (seg_len_reg == '0) begin
                                dot0_next = (s_in_byte == CHAR_DOT);
                            end
                            if (seg_len_reg == SLW'(1)) begin
                                dot1_next = (s_in_byte == CHAR_DOT);
                            end
                        end
                        if (is_nul) begin
                            ended_next = 1'b1;
                        end
                        if (is_nul || is_sep || s_in_last) begin
                            state_next = ST_FIN;
                        end
                    end else if (s_in_last) begin
                        state_next = ST_EM_RD;
                    end
                end
            end
            ST_FIN: begin
                push_len_next = seg_len_reg;
                seg_len_next  = '0;
                idx_next      = '0;
                if ((seg_len_reg == '0) || ((seg_len_reg == SLW'(1)) && dot0_reg)) begin
                    state_next = done_state;
                end else if ((seg_len_reg == SLW'(2)) && dot0_reg && dot1_reg) begin
                    state_next = ST_POP_RD;
                end else begin
                    state_next = ST_PUSH_SL;
                end
            end
            ST_PUSH_SL: begin
                if (room_out && !ends_slash_reg) begin
                    res_we          = 1'b1;
                    res_len_next    = res_len_reg + RAW'(1);
                    ends_slash_next = 1'b1;
                end
                state_next = ST_PUSH_RD;
            end
            ST_PUSH_RD: begin
                if ((idx_reg < push_len_reg) && room_out) begin
                    state_next = ST_PUSH_WR;
                end else begin
                    state_next = done_state;
                end
            end
            ST_PUSH_WR: begin
                res_we          = 1'b1;
                res_wdata       = seg_rdata;
                res_len_next    = res_len_reg + RAW'(1);
                idx_next        = idx_reg + SLW'(1);
                ends_slash_next = 1'b0;
                state_next      = ST_PUSH_RD;
            end
            ST_POP_RD: begin
                if (res_len_reg > RAW'(1)) begin
                    state_next = ST_POP_CK;
                end else begin
                    ends_slash_next = 1'b1;
                    state_next      = done_state;
                end
            end
            ST_POP_CK: begin
                res_len_next = res_len_reg - RAW'(1);
                if (res_rdata == CHAR_SLASH) begin
                    ends_slash_next = (res_len_reg == RAW'(2));
                    state_next      = done_state;
                end else begin
                    state_next = ST_POP_RD;
                end
            end
            ST_EM_RD: begin
                res_raddr = emit_idx_reg;
                if (!m_valid || m_ready) begin
                    state_next = ST_EM_LD;
                end
            end
            ST_EM_LD: begin
                out_ld.load   = 1'b1;
                emit_idx_next = emit_idx_reg + RAW'(1);
                if (emit_last) begin
                    emit_idx_next   = '0;
                    res_len_next    = RAW'(1);
                    seg_len_next    = '0;
                    ends_slash_next = 1'b1;
                    ended_next      = 1'b0;
                    last_pend_next  = 1'b0;
                    state_next      = ST_IDLE;
                end else begin
                    state_next = ST_EM_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seg_len_reg    <= '0;
            res_len_reg    <= RAW'(1);
            ends_slash_reg <= 1'b1;
            ended_reg      <= 1'b0;
            last_pend_reg  <= 1'b0;
            emit_idx_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            seg_len_reg    <= seg_len_next;
            res_len_reg    <= res_len_next;
            ends_slash_reg <= ends_slash_next;
            ended_reg      <= ended_next;
            last_pend_reg  <= last_pend_next;
            emit_idx_reg   <= emit_idx_next;
        end
        push_len_reg <= push_len_next;
        idx_reg      <= idx_next;
        dot0_reg     <= dot0_next;
        dot1_reg     <= dot1_next;
    end

    apn_ram #(
        .WIDTH (8),
        .DEPTH (SEGMENT_BYTES - 1)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (seg_len_reg[SAW-1:0]),
        .wdata (s_in_byte),
        .raddr (idx_reg[SAW-1:0]),
        .rdata (seg_rdata)
    );

    apn_ram #(
        .WIDTH (8),
        .DEPTH (OUT_BYTES)
    ) u_res_ram (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    apn_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld         (out_ld),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

// ===== hdl/apn_checker.sv =====
// apn_checker: port-level assertions on the absolute path normaliser, bound to the top level
// depends on apn_pkg and absolute_path_normalizer_unit
`timescale 1ns / 1ps

module apn_checker
    import apn_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_in_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_last
);

    logic first_reg;

    // the next result transaction opens a path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            first_reg <= m_out_last;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_in_last))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("result transaction changed under stall");

    a_no_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_byte != CHAR_NUL)
        else $error("zero byte in normalised path");

    a_root_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && first_reg |-> m_out_byte == CHAR_SLASH)
        else $error("path does not start at the root");

    a_no_input_mid_path: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_last |-> !s_ready)
        else $error("input taken while a path is being emitted");

endmodule

bind absolute_path_normalizer_unit apn_checker u_apn_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_in_byte  (s_in_byte),
    .s_in_last  (s_in_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last)
);

// ===== tb/apn_path_checker.sv =====
// apn_path_checker: watches both channels of the path normaliser, predicts the
// normalised path for every input transaction and compares each output byte
// depends on apn_pkg
`timescale 1ns / 1ps

module apn_path_checker
    import apn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_out_last,
    output int         mismatch_count,
    output int         pending_chars,
    output int         chars_checked
);

    localparam int NAME_MAX = APN_SEGMENT_BYTES - 1;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } path_char_t;

    logic [7:0] name_buf [NAME_MAX];
    int         name_len;
    logic [7:0] canon_buf [APN_OUT_BYTES];
    int         canon_len;
    bit         nul_seen;
    path_char_t canon_q [$];
    int         fail_tally = 0;
    int         checked_tally = 0;

    function automatic void clear_path();
        canon_buf[0] = CHAR_SLASH;
        canon_len    = 1;
        name_len     = 0;
        nul_seen     = 1'b0;
    endfunction

    // closes the component being collected: drop, pop or append
    function automatic void close_name();
        int n;
        int k;
        n        = name_len;
        name_len = 0;
        if (n == 0)
            return;
        if (n == 1 && name_buf[0] == CHAR_DOT)
            return;
        if (n == 2 && name_buf[0] == CHAR_DOT && name_buf[1] == CHAR_DOT) begin
            k = canon_len;
            if (k <= 1)
                return;
            while (k > 1 && canon_buf[k - 1] != CHAR_SLASH)
                k--;
            if (k > 1)
                k--;
            canon_len = k;
            return;
        end
        k = canon_len;
        if (k + 1 < APN_OUT_BYTES && canon_buf[k - 1] != CHAR_SLASH) begin
            canon_buf[k] = CHAR_SLASH;
            k++;
        end
        for (int i = 0; i < n && k + 1 < APN_OUT_BYTES; i++) begin
            canon_buf[k] = name_buf[i];
            k++;
        end
        canon_len = k;
    endfunction

    always @(posedge aclk) begin
        path_char_t want;
        if (!aresetn) begin
            clear_path();
            canon_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (!nul_seen) begin
                    if (s_in_byte == CHAR_NUL) begin
                        close_name();
                        nul_seen = 1'b1;
                    end else if (s_in_byte == CHAR_SLASH || s_in_byte == CHAR_BSLASH) begin
                        close_name();
                    end else if (name_len < NAME_MAX) begin
                        name_buf[name_len] = s_in_byte;
                        name_len++;
                    end
                end
                if (s_in_last) begin
                    if (!nul_seen)
                        close_name();
                    for (int i = 0; i < canon_len; i++)
                        canon_q.push_back('{ch: canon_buf[i], fin: (i == canon_len - 1)});
                    clear_path();
                end
            end
            if (m_valid && m_ready) begin
                checked_tally++;
                if (canon_q.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("unexpected output byte %02h last %0b", m_out_byte, m_out_last);
                end else begin
                    want = canon_q.pop_front();
                    if (want.ch !== m_out_byte || want.fin !== m_out_last) begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display("mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.ch, want.fin, m_out_byte, m_out_last);
                    end
                end
            end
        end
        mismatch_count <= fail_tally;
        pending_chars  <= canon_q.size();
        chars_checked  <= checked_tally;
    end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives paths into absolute_path_normalizer_unit and gives the verdict
// depends on apn_pkg, the block itself and apn_path_checker
`timescale 1ns / 1ps

module testbench
    import apn_pkg::*;
();

    localparam int TARGET_BYTES   = 150;
    localparam int CALM_BYTES     = 125;
    localparam int WATCHDOG_LIMIT = 5000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    int         mismatch_count;
    int         pending_chars;
    int         chars_checked;

    logic [7:0] path_chars [$];
    bit         calm = 1'b0;
    int         stall_left = 0;
    int         bytes_sent = 0;
    int         paths_sent = 0;

    always #2 aclk = ~aclk;

    absolute_path_normalizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_last(m_out_last)
    );

    apn_path_checker path_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_out_last    (m_out_last),
        .mismatch_count(mismatch_count),
        .pending_chars (pending_chars),
        .chars_checked (chars_checked)
    );

    // receiver back-pressure in random bursts of low m_ready
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= c;
        s_in_last <= fin;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_path();
        foreach (path_chars[i])
            send_char(path_chars[i], i == path_chars.size() - 1);
        paths_sent++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_chars != 0)
            @(posedge aclk);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            path_chars.push_back(txt[i]);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = CHAR_DOT;
            1: begin
                c = 8'($urandom_range(1, 255));
                if (c == CHAR_SLASH || c == CHAR_BSLASH)
                    c = 8'h7F;
            end
            default: c = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        return c;
    endfunction

    function automatic void add_separators();
        repeat ($urandom_range(1, 3))
            path_chars.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
    endfunction

    // mostly well-formed paths; wide ones use long names to hit truncation and a full path
    task automatic build_random_path(input bit wide);
        int parts;
        int kind;
        int n;
        path_chars.delete();
        if (!wide && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10))
                path_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        parts = wide ? $urandom_range(3, 4) : $urandom_range(1, 5);
        if ($urandom_range(0, 3) != 0)
            add_separators();
        repeat (parts) begin
            kind = wide ? 9 : $urandom_range(0, 9);
            if (kind < 2) begin
                path_chars.push_back(CHAR_DOT);
            end else if (kind < 4) begin
                path_chars.push_back(CHAR_DOT);
                path_chars.push_back(CHAR_DOT);
            end else begin
                n = wide ? $urandom_range(10, 34) : $urandom_range(1, 6);
                repeat (n)
                    path_chars.push_back(name_char());
            end
            add_separators();
        end
        if ($urandom_range(0, 1))
            while (path_chars[$] == CHAR_SLASH || path_chars[$] == CHAR_BSLASH)
                void'(path_chars.pop_back());
        if ($urandom_range(0, 7) == 0)
            path_chars.insert($urandom_range(0, path_chars.size() - 1), CHAR_NUL);
    endtask

    initial begin
        bit first_random;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // zero byte alone, dot-dot at the root, mixed separators with a dot
        path_chars = {CHAR_NUL};
        send_path();
        path_chars.delete();
        add_text("..");
        send_path();
        path_chars.delete();
        add_text("\\/ab/./c");
        send_path();

        s_valid <= 1'b0;
        wait_drained();

        // pop of a component, extreme bytes with trailing garbage after a zero byte
        path_chars.delete();
        add_text("x/..\\y");
        send_path();
        path_chars = {8'hFF, 8'h01, CHAR_NUL, 8'h71, CHAR_SLASH};
        send_path();
        path_chars.delete();
        add_text(".a/.../.");
        send_path();

        first_random = 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            build_random_path(first_random || $urandom_range(0, 11) == 0);
            first_random = 1'b0;
            if (bytes_sent >= CALM_BYTES)
                calm = 1'b1;
            send_path();
        end

        s_valid <= 1'b0;
        calm = 1'b1;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("run covered %0d paths, %0d input bytes and %0d output bytes checked",
                 paths_sent, bytes_sent, chars_checked);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
